// File: rtl/iafp_pkg.sv
// Package for the accelerometer frame parser with zero calibration.
// Holds phase and controller state types, frame constants and reset values.
// No dependencies.
`default_nettype none
package iafp_pkg;
    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] TYPE_BYTE = 8'h51;
    localparam logic [15:0] THRESH_RESET = 16'd100;
    localparam logic [9:0] SAMPLES_RESET = 10'd50;
    localparam int BURST_MAX_DEF = 64;
    localparam int SUM_W = 26;
    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_SAMPLES = 1'b1;

    typedef enum logic [1:0] {
        PH_SYNC  = 2'd0,
        PH_TYPE  = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CAL   = 3'd1,
        ST_DIV   = 3'd2,
        ST_OUT   = 3'd3,
        ST_WAIT  = 3'd4
    } ctl_state_t;

    typedef struct packed {
        logic parse;
        logic cal_step;
        logic div_start;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic fire;
        logic need_div;
        logic div_done;
    } ctl_sts_t;
endpackage
`default_nettype wire

// File: rtl/iafp_div.sv
// Serial restoring divider for rounded offsets, one quotient bit per cycle.
// Depends on iafp_pkg.
`default_nettype none
module iafp_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [iafp_pkg::SUM_W-1:0] dividend,
    input  wire logic [9:0]                 divisor,
    output logic      [iafp_pkg::SUM_W-1:0] quotient,
    output logic                            done
);
    logic [4:0]                  cnt_reg;
    logic                        busy_reg;
    logic [iafp_pkg::SUM_W-1:0]  q_reg;
    logic [10:0]                 rem_reg;
    logic [10:0]                 shifted;
    logic [10:0]                 diff;

    assign shifted = {rem_reg[9:0], q_reg[iafp_pkg::SUM_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(iafp_pkg::SUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[10]) begin
                rem_reg <= diff;
                q_reg   <= {q_reg[iafp_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[iafp_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
endmodule
`default_nettype wire

// File: rtl/iafp_ctrl.sv
// Controller state machine: sequences parse, calibration, division, output.
// Depends on iafp_pkg.
`default_nettype none
module iafp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire iafp_pkg::ctl_sts_t   sts,
    output iafp_pkg::ctl_cmd_t        cmd
);
    iafp_pkg::ctl_state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iafp_pkg::ST_IDLE;
            axis_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        mv_next    = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            iafp_pkg::ST_IDLE: begin
                if (s_valid && sts.fire) state_next = iafp_pkg::ST_CAL;
            end
            iafp_pkg::ST_CAL: begin
                axis_next  = 2'd0;
                state_next = sts.need_div ? iafp_pkg::ST_DIV : iafp_pkg::ST_WAIT;
            end
            iafp_pkg::ST_DIV: state_next = iafp_pkg::ST_WAIT;
            iafp_pkg::ST_WAIT: begin
                if (axis_reg == 2'd3) begin
                    if (!mv_reg || m_ready) state_next = iafp_pkg::ST_OUT;
                end else if (sts.div_done) begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? iafp_pkg::ST_WAIT
                                                    : iafp_pkg::ST_DIV;
                end
            end
            iafp_pkg::ST_OUT: begin
                mv_next    = 1'b1;
                state_next = iafp_pkg::ST_IDLE;
            end
            default: state_next = iafp_pkg::ST_IDLE;
        endcase
        if (state_reg == iafp_pkg::ST_CAL && !sts.need_div) axis_next = 2'd3;
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        case (state_reg)
            iafp_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.parse = s_valid;
            end
            iafp_pkg::ST_CAL:  cmd.cal_step  = 1'b1;
            iafp_pkg::ST_DIV:  cmd.div_start = 1'b1;
            iafp_pkg::ST_OUT:  cmd.out_load  = 1'b1;
            default: ;
        endcase
    end

    assign m_valid = mv_reg;
endmodule
`default_nettype wire

// File: rtl/iafp_dp.sv
// Datapath: frame parser, calibration accumulators, offset rounding and outputs.
// Depends on iafp_pkg and iafp_div.
`default_nettype none
module iafp_dp #(
    parameter int BURST_MAX = iafp_pkg::BURST_MAX_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               burst_end,
    input  wire logic [15:0]        motion_threshold,
    input  wire logic [9:0]         calib_samples,
    input  wire iafp_pkg::ctl_cmd_t cmd,
    output iafp_pkg::ctl_sts_t      sts,
    output logic signed [15:0]      raw_x,
    output logic signed [15:0]      raw_y,
    output logic signed [15:0]      raw_z,
    output logic signed [15:0]      temperature_raw,
    output logic signed [16:0]      cal_x,
    output logic signed [16:0]      cal_y,
    output logic signed [16:0]      cal_z,
    output logic                    calibrated,
    output logic [9:0]              calib_progress
);
    localparam int CW = $clog2(BURST_MAX + 1);
    localparam int SW = iafp_pkg::SUM_W;

    iafp_pkg::phase_t   phase_reg;
    logic [7:0]         fb_reg [8];
    logic [2:0]         idx_reg;
    logic [7:0]         sum_reg;
    logic [CW-1:0]      bcnt_reg;
    logic               had_reg;
    logic signed [15:0] lat_reg [4];
    logic signed [15:0] prev_reg [3];
    logic               havep_reg;
    logic signed [SW-1:0] asum_reg [3];
    logic [9:0]         cnt_reg;
    logic signed [15:0] off_reg [3];
    logic               cal_reg;
    logic [1:0]         ax_reg;
    logic [7:0]         sum_b;

    assign sum_b = sum_reg + rx_byte;
    assign sts.fire = burst_end && (had_reg ||
        (phase_reg == iafp_pkg::PH_CHECK && rx_byte == sum_reg &&
         bcnt_reg < CW'(BURST_MAX)));

    // calibration step terms
    logic [2:0]  moved;
    logic        mv_any;
    logic [9:0]  cnt_new;
    logic [9:0]  target;
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [16:0] d;
            logic [16:0] m;
            d = 17'(lat_reg[a]) - 17'(prev_reg[a]);
            m = d[16] ? 17'(-d) : 17'(d);
            moved[a] = m > {1'b0, motion_threshold};
        end
        mv_any  = havep_reg && (|moved);
        cnt_new = (mv_any ? 10'd0 : cnt_reg) + 10'd1;
        target  = (calib_samples == 10'd0) ? 10'd1 : calib_samples;
    end
    assign sts.need_div = !cal_reg && (cnt_new >= target);

    // rounded division by magnitude
    logic signed [SW-1:0] dsum;
    logic [SW-1:0] dmag, quo;
    logic          dneg_reg;
    logic          ddone;
    always_comb begin
        case (ax_reg)
            2'd0:    dsum = asum_reg[0];
            2'd1:    dsum = asum_reg[1];
            default: dsum = asum_reg[2];
        endcase
        dmag = (dsum[SW-1] ? SW'(-dsum) : SW'(dsum)) + SW'(cnt_reg >> 1);
    end
    iafp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(dmag), .divisor(cnt_reg), .quotient(quo), .done(ddone)
    );
    assign sts.div_done = ddone;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= iafp_pkg::PH_SYNC;
            idx_reg   <= '0;
            sum_reg   <= '0;
            bcnt_reg  <= '0;
            had_reg   <= 1'b0;
            havep_reg <= 1'b0;
            cnt_reg   <= '0;
            cal_reg   <= 1'b0;
            ax_reg    <= '0;
            for (int a = 0; a < 4; a++) lat_reg[a] <= '0;
            for (int a = 0; a < 3; a++) begin
                prev_reg[a] <= '0;
                asum_reg[a] <= '0;
                off_reg[a]  <= '0;
            end
        end else begin
            if (cmd.parse) begin
                if (bcnt_reg < CW'(BURST_MAX)) begin
                    bcnt_reg <= bcnt_reg + CW'(1);
                    case (phase_reg)
                        iafp_pkg::PH_SYNC: begin
                            if (rx_byte == iafp_pkg::SYNC_BYTE) begin
                                phase_reg <= iafp_pkg::PH_TYPE;
                                sum_reg   <= iafp_pkg::SYNC_BYTE;
                            end
                        end
                        iafp_pkg::PH_TYPE: begin
                            sum_reg <= sum_b;
                            idx_reg <= '0;
                            phase_reg <= (rx_byte == iafp_pkg::TYPE_BYTE) ?
                                iafp_pkg::PH_DATA : iafp_pkg::PH_SYNC;
                        end
                        iafp_pkg::PH_DATA: begin
                            fb_reg[idx_reg] <= rx_byte;
                            sum_reg <= sum_b;
                            if (idx_reg == 3'd7) phase_reg <= iafp_pkg::PH_CHECK;
                            else idx_reg <= idx_reg + 3'd1;
                        end
                        default: begin
                            if (rx_byte == sum_reg) begin
                                for (int a = 0; a < 4; a++)
                                    lat_reg[a] <= {fb_reg[2*a+1], fb_reg[2*a]};
                                had_reg <= 1'b1;
                            end
                            phase_reg <= iafp_pkg::PH_SYNC;
                        end
                    endcase
                end
                if (burst_end) begin
                    phase_reg <= iafp_pkg::PH_SYNC;
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                    bcnt_reg  <= '0;
                    had_reg   <= 1'b0;
                end
            end
            if (cmd.cal_step && !cal_reg) begin
                for (int a = 0; a < 3; a++) begin
                    prev_reg[a] <= lat_reg[a];
                    asum_reg[a] <= (mv_any ? SW'(0) : asum_reg[a]) + SW'(lat_reg[a]);
                end
                havep_reg <= 1'b1;
                cnt_reg   <= cnt_new;
                ax_reg    <= '0;
            end
            if (cmd.div_start) dneg_reg <= dsum[SW-1];
            if (ddone) begin
                off_reg[ax_reg] <= dneg_reg ? 16'(-quo) : 16'(quo);
                ax_reg <= ax_reg + 2'd1;
                if (ax_reg == 2'd2) cal_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            raw_x <= lat_reg[0];
            raw_y <= lat_reg[1];
            raw_z <= lat_reg[2];
            temperature_raw <= lat_reg[3];
            cal_x <= cal_reg ? 17'(lat_reg[0]) - 17'(off_reg[0]) : '0;
            cal_y <= cal_reg ? 17'(lat_reg[1]) - 17'(off_reg[1]) : '0;
            cal_z <= cal_reg ? 17'(lat_reg[2]) - 17'(off_reg[2]) : '0;
            calibrated <= cal_reg;
            calib_progress <= cnt_reg;
        end
    end
endmodule
`default_nettype wire

// File: rtl/imu_accel_frame_parser_zero_cal.sv
// Top level of the accelerometer frame parser with zero calibration.
// Depends on iafp_pkg, iafp_ctrl and iafp_dp.
//
//   channel | signals                          | role
//   s_      | s_valid s_ready rx_byte burst_end | serial bytes in
//   m_      | m_valid m_ready raw/cal/status    | one result per good burst
//   cfg_    | cfg_valid cfg_ready index data    | register writes
//
// Bytes are taken while the controller is idle; a burst end with a frame
// runs calibration and, for new offsets, one serial division per axis.
// Synchronous active-low reset clears all control and calibration state.
// A result waits in the output register; the next byte is taken meanwhile,
// but a new result holds until the previous one is transferred.
`default_nettype none
module imu_accel_frame_parser_zero_cal #(
    parameter int BURST_MAX = iafp_pkg::BURST_MAX_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_burst_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_raw_x,
    output logic signed [15:0]      m_raw_y,
    output logic signed [15:0]      m_raw_z,
    output logic signed [15:0]      m_temperature_raw,
    output logic signed [16:0]      m_cal_x,
    output logic signed [16:0]      m_cal_y,
    output logic signed [16:0]      m_cal_z,
    output logic                    m_calibrated,
    output logic [9:0]              m_calib_progress,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    iafp_pkg::ctl_cmd_t cmd;
    iafp_pkg::ctl_sts_t sts;
    logic [15:0] thresh_reg;
    logic [9:0]  samples_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= iafp_pkg::THRESH_RESET;
            samples_reg <= iafp_pkg::SAMPLES_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == iafp_pkg::CFG_THRESH) thresh_reg <= cfg_data;
            else if (cfg_index == iafp_pkg::CFG_SAMPLES) samples_reg <= cfg_data[9:0];
        end
    end

    iafp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    iafp_dp #(.BURST_MAX(BURST_MAX)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .rx_byte(s_rx_byte),
        .burst_end(s_burst_end), .motion_threshold(thresh_reg),
        .calib_samples(samples_reg), .cmd(cmd), .sts(sts),
        .raw_x(m_raw_x), .raw_y(m_raw_y), .raw_z(m_raw_z),
        .temperature_raw(m_temperature_raw), .cal_x(m_cal_x), .cal_y(m_cal_y),
        .cal_z(m_cal_z), .calibrated(m_calibrated),
        .calib_progress(m_calib_progress)
    );
endmodule
`default_nettype wire

// File: rtl/iafp_checker.sv
// Port-level checker for the frame parser top level, with its bind.
// Depends on nothing beyond the top level's ports.
`default_nettype none
module iafp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_calibrated,
    input wire logic [9:0] m_calib_progress
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_calibrated |=> !m_valid || m_calibrated)
        else $error("calibration lost");
    a_prog_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_calib_progress != 10'd0) else $error("zero progress");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind imu_accel_frame_parser_zero_cal iafp_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_calibrated(m_calibrated),
    .m_calib_progress(m_calib_progress)
);
`default_nettype wire

// File: tb/sv/tb_imu_accel_frame_parser_zero_cal.sv
// Testbench for imu_accel_frame_parser_zero_cal: drives bursts of serial bytes,
// predicts each burst's result and compares it field by field with the output.
// Depends on iafp_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_imu_accel_frame_parser_zero_cal;
    localparam int BMAX = iafp_pkg::BURST_MAX_DEF;

    typedef struct packed {
        logic [7:0] rx;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic signed [15:0] rx_, ry, rz, rt;
        logic signed [16:0] cx, cy, cz;
        logic               cal;
        logic [9:0]         prog;
    } imu_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_ready, s_burst_end = 1'b0;
    logic [7:0] s_rx_byte = 8'd0;
    logic m_valid, m_ready = 1'b0;
    logic signed [15:0] m_raw_x, m_raw_y, m_raw_z, m_temperature_raw;
    logic signed [16:0] m_cal_x, m_cal_y, m_cal_z;
    logic m_calibrated;
    logic [9:0] m_calib_progress;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [0:0] cfg_index = iafp_pkg::CFG_THRESH;
    logic [15:0] cfg_data = 16'd0;

    imu_accel_frame_parser_zero_cal u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    byte_item_t  pending_bytes[$];
    imu_result_t expected_results[$];
    int errors = 0;
    int idle_pct = 0, stall_pct = 0;
    logic stall_hold = 1'b0;
    logic hold_active;
    logic s_ready_q = 1'b0;

    // predictor state
    logic [15:0]       thr;
    logic [9:0]        nsamp;
    iafp_pkg::phase_t  ph;
    logic [7:0]        fb[8];
    int                fidx, bcount;
    logic [7:0]        rsum;
    logic              had_frame, have_prev, is_cal;
    int                lat[4], prv[3], sums[3], offs[3];
    int                still;

    function automatic int word16(logic [7:0] lo, logic [7:0] hi);
        return int'($signed({hi, lo}));
    endfunction

    function automatic int round_div(int s, int d);
        if (s >= 0) return (s + d / 2) / d;
        return -((-s + d / 2) / d);
    endfunction

    task automatic predict_byte(byte_item_t it);
        int moved, dd, tgt;
        imu_result_t r;
        if (bcount < BMAX) begin
            bcount++;
            case (ph)
                iafp_pkg::PH_SYNC: if (it.rx == iafp_pkg::SYNC_BYTE) begin
                    ph = iafp_pkg::PH_TYPE;
                    rsum = iafp_pkg::SYNC_BYTE;
                end
                iafp_pkg::PH_TYPE: begin
                    rsum += it.rx;
                    ph = (it.rx == iafp_pkg::TYPE_BYTE) ? iafp_pkg::PH_DATA
                                                        : iafp_pkg::PH_SYNC;
                    fidx = 0;
                end
                iafp_pkg::PH_DATA: begin
                    fb[fidx] = it.rx;
                    rsum += it.rx;
                    if (fidx >= 7) ph = iafp_pkg::PH_CHECK;
                    else fidx++;
                end
                default: begin
                    if (it.rx == rsum) begin
                        for (int a = 0; a < 4; a++) lat[a] = word16(fb[2*a], fb[2*a+1]);
                        had_frame = 1'b1;
                    end
                    ph = iafp_pkg::PH_SYNC;
                end
            endcase
        end
        if (!it.last) return;
        ph = iafp_pkg::PH_SYNC;
        fidx = 0;
        rsum = 8'd0;
        bcount = 0;
        if (!had_frame) return;
        had_frame = 1'b0;
        if (!is_cal) begin
            moved = 0;
            if (have_prev)
                for (int a = 0; a < 3; a++) begin
                    dd = lat[a] - prv[a];
                    if (dd < 0) dd = -dd;
                    if (dd > int'(thr)) moved = 1;
                end
            if (moved) begin
                sums = '{0, 0, 0};
                still = 0;
            end
            for (int a = 0; a < 3; a++) begin
                prv[a] = lat[a];
                sums[a] += lat[a];
            end
            have_prev = 1'b1;
            still++;
            tgt = (nsamp == 10'd0) ? 1 : int'(nsamp);
            if (still >= tgt) begin
                for (int a = 0; a < 3; a++) offs[a] = round_div(sums[a], still);
                is_cal = 1'b1;
            end
        end
        r.rx_ = 16'(lat[0]); r.ry = 16'(lat[1]); r.rz = 16'(lat[2]); r.rt = 16'(lat[3]);
        r.cx = is_cal ? 17'(lat[0] - offs[0]) : 17'sd0;
        r.cy = is_cal ? 17'(lat[1] - offs[1]) : 17'sd0;
        r.cz = is_cal ? 17'(lat[2] - offs[2]) : 17'sd0;
        r.cal = is_cal;
        r.prog = 10'(still);
        expected_results.push_back(r);
    endtask

    task automatic predictor_reset();
        thr = iafp_pkg::THRESH_RESET; nsamp = iafp_pkg::SAMPLES_RESET;
        ph = iafp_pkg::PH_SYNC;
        fidx = 0; bcount = 0; rsum = 8'd0; had_frame = 1'b0; have_prev = 1'b0;
        is_cal = 1'b0;
        lat = '{0, 0, 0, 0}; prv = '{0, 0, 0}; sums = '{0, 0, 0};
        offs = '{0, 0, 0}; still = 0;
    endtask

    // driver
    always @(negedge aclk) begin
        byte_item_t it;
        if (aresetn && (!s_valid || s_ready_q)) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
                it = pending_bytes.pop_front();
                predict_byte(it);
                s_rx_byte <= it.rx;
                s_burst_end <= it.last;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= hold_active ? 1'b0 : ($urandom_range(99) >= stall_pct);
    end

    // acceptance seen at the rising edge, used by the driver at the next falling edge
    always @(posedge aclk) begin
        s_ready_q <= s_valid && s_ready;
    end

    // long receiver hold-off, counted in cycles
    initial begin
        hold_active = 1'b0;
        wait (stall_hold);
        hold_active = 1'b1;
        repeat (2000) @(posedge aclk);
        hold_active = 1'b0;
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            imu_result_t e;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_raw_x !== e.rx_) begin
                    $error("raw_x exp %0d got %0d", e.rx_, m_raw_x); errors++; end
                if (m_raw_y !== e.ry) begin
                    $error("raw_y exp %0d got %0d", e.ry, m_raw_y); errors++; end
                if (m_raw_z !== e.rz) begin
                    $error("raw_z exp %0d got %0d", e.rz, m_raw_z); errors++; end
                if (m_temperature_raw !== e.rt) begin
                    $error("temperature_raw exp %0d got %0d", e.rt, m_temperature_raw);
                    errors++;
                end
                if (m_cal_x !== e.cx) begin
                    $error("cal_x exp %0d got %0d", e.cx, m_cal_x); errors++; end
                if (m_cal_y !== e.cy) begin
                    $error("cal_y exp %0d got %0d", e.cy, m_cal_y); errors++; end
                if (m_cal_z !== e.cz) begin
                    $error("cal_z exp %0d got %0d", e.cz, m_cal_z); errors++; end
                if (m_calibrated !== e.cal) begin
                    $error("calibrated exp %0d got %0d", e.cal, m_calibrated); errors++; end
                if (m_calib_progress !== e.prog) begin
                    $error("calib_progress exp %0d got %0d", e.prog, m_calib_progress);
                    errors++;
                end
            end
        end
    end

    function automatic logic [15:0] near_val(logic [15:0] base, int spread);
        return base + 16'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic add_frame(logic [15:0] x, y, z, t, bit bad_check);
        logic [7:0] bs[11];
        logic [7:0] s;
        bs = '{iafp_pkg::SYNC_BYTE, iafp_pkg::TYPE_BYTE, x[7:0], x[15:8], y[7:0],
               y[15:8], z[7:0], z[15:8], t[7:0], t[15:8], 8'd0};
        s = 8'd0;
        for (int i = 0; i < 10; i++) s += bs[i];
        bs[10] = bad_check ? s + 8'(1 + $urandom_range(254)) : s;
        for (int i = 0; i < 11; i++) pending_bytes.push_back('{bs[i], 1'b0});
    endtask

    task automatic end_burst(logic [7:0] b);
        pending_bytes.push_back('{b, 1'b1});
    endtask

    task automatic wait_drain();
        while (pending_bytes.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == iafp_pkg::CFG_THRESH) thr = val;
        else nsamp = val[9:0];
    endtask

    // random burst: mostly clean frames near a base, some noise and broken frames
    task automatic random_burst(logic [15:0] bx, by, bz, int spread);
        int n;
        n = $urandom_range(1, 4);
        for (int f = 0; f < n; f++) begin
            case ($urandom_range(9))
                0: pending_bytes.push_back('{8'($urandom), 1'b0});
                1: add_frame(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1);
                2: begin
                    pending_bytes.push_back('{iafp_pkg::SYNC_BYTE, 1'b0});
                    pending_bytes.push_back('{8'($urandom), 1'b0});
                end
                default: add_frame(near_val(bx, spread), near_val(by, spread),
                                   near_val(bz, spread), 16'($urandom), 0);
            endcase
        end
        if ($urandom_range(9) == 0)
            for (int i = 0; i < 12; i++)
                pending_bytes.push_back('{iafp_pkg::SYNC_BYTE, 1'b0});
        end_burst($urandom_range(3) == 0 ? iafp_pkg::SYNC_BYTE : 8'($urandom));
    endtask

    task automatic random_phase(int nbytes, int spread);
        logic [15:0] bx, by, bz;
        int target;
        bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
        target = pending_bytes.size() + nbytes;
        while (pending_bytes.size() < target) random_burst(bx, by, bz, spread);
    endtask

    initial begin
        predictor_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, bad type, bad check, cut frame, overlong burst
        write_reg(iafp_pkg::CFG_SAMPLES, 16'd3);
        add_frame(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 0);
        end_burst(8'h00);
        pending_bytes.push_back('{iafp_pkg::SYNC_BYTE, 1'b0});
        pending_bytes.push_back('{8'h52, 1'b0});
        add_frame(16'h0001, 16'h0002, 16'h0003, 16'h8000, 1);
        end_burst(8'hFF);
        add_frame(16'h7FF0, 16'h8010, 16'h0005, 16'h1234, 0);
        pending_bytes.push_back('{iafp_pkg::SYNC_BYTE, 1'b0});
        end_burst(iafp_pkg::TYPE_BYTE);
        for (int i = 0; i < 70; i++) pending_bytes.push_back('{iafp_pkg::SYNC_BYTE, 1'b0});
        end_burst(8'h00);
        add_frame(16'h7FF5, 16'h8008, 16'h0001, 16'h0000, 0);
        end_burst(8'hAA);
        wait_drain();

        idle_pct = 0; stall_pct = 0;
        write_reg(iafp_pkg::CFG_THRESH, 16'd0);
        write_reg(iafp_pkg::CFG_SAMPLES, 16'd0);
        random_phase(200, 0);
        wait_drain();

        idle_pct = 69; stall_pct = 0;
        write_reg(iafp_pkg::CFG_THRESH, 16'hFFFF);
        write_reg(iafp_pkg::CFG_SAMPLES, 16'd1023);
        random_phase(250, 30000);
        wait_drain();

        // receiver stalls; long hold-off to fill the block
        idle_pct = 0; stall_pct = 69;
        write_reg(iafp_pkg::CFG_THRESH, 16'd40);
        write_reg(iafp_pkg::CFG_SAMPLES, 16'd4);
        stall_hold = 1'b1;
        random_phase(300, 30);
        wait_drain();

        idle_pct = 7; stall_pct = 7;
        write_reg(iafp_pkg::CFG_THRESH, 16'd100);
        write_reg(iafp_pkg::CFG_SAMPLES, 16'd2);
        random_phase(220, 120);
        wait_drain();

        if (errors == 0)
            $display("tb_imu_accel_frame_parser_zero_cal: clean");
        else
            $display("tb_imu_accel_frame_parser_zero_cal: errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_imu_accel_frame_parser_zero_cal: errors");
        $finish;
    end
endmodule

// File: filelist.f
rtl/iafp_pkg.sv
rtl/iafp_div.sv
rtl/iafp_ctrl.sv
rtl/iafp_dp.sv
rtl/imu_accel_frame_parser_zero_cal.sv
rtl/iafp_checker.sv
tb/sv/tb_imu_accel_frame_parser_zero_cal.sv
